[rtl/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants of the segmented address translator
// Holds the segment table size, function codes, register indexes and the
// layout of one stored table entry.
// ----------------------------------------------------------------------------
package sat_pkg;

	// Table size and derived index widths.
	localparam int MAX_SEGMENTS = 10;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

	// Fixed field widths of the word interface.
	localparam int ADDR_W     = 64;
	localparam int FUNC_W     = 2;
	localparam int SEG_IDX_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int AW_REG_W   = 6;
	localparam int CNT_REG_W  = 4;

	// Reset values of the configuration registers.
	localparam logic [AW_REG_W-1:0]  AW_RESET  = 6'd36;
	localparam logic [CNT_REG_W-1:0] CNT_RESET = 4'd1;

	// Function codes of an input word.
	typedef enum logic [FUNC_W-1:0] {
		FN_WRITE   = 2'd0,
		FN_FORWARD = 2'd1,
		FN_REVERSE = 2'd2,
		FN_UNUSED  = 2'd3
	} func_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADDR_WIDTH = 2'd0,
		CFG_SEG_COUNT  = 2'd1,
		CFG_FWD_ENABLE = 2'd2,
		CFG_NONE       = 2'd3
	} cfg_idx_t;

	// One stored segment: start, raw offset and bad mark.
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] shift;
		logic              bad;
	} seg_entry_t;

endpackage

[rtl/segmented_address_translator_core.sv]
// ----------------------------------------------------------------------------
// segmented_address_translator_core: segment table address translator
// Keeps a table of base/offset segments in a RAM and answers write, forward
// and reverse lookup words by walking the table one entry at a time.
// ----------------------------------------------------------------------------
// Usage:
// An input word is taken at a clock edge where start is high and busy is low.
// func selects a segment write, a forward (system to memory) lookup or a
// reverse (memory to system) lookup. Every word gives one result word on
// result_addr and status, shown for one cycle with done high; the receiver
// has no way to stall it and must take it in that cycle.
// A segment write, a forward lookup with translation off, a lookup with no
// segment in use and an unknown func finish at once: done is high in
// the cycle after acceptance. A table walk reads one entry at a time
// (read, load, add, compare) through the single RAM read port; busy is
// high for the whole walk and low again in the cycle that shows done, so a
// new word may start there.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while the
// block is idle. Reset clears all entry valid bits, so every segment reads as
// zero until written, and loads the register reset values.
// ----------------------------------------------------------------------------
module segmented_address_translator_core
	import sat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic [FUNC_W-1:0]     func,
	input  logic [SEG_IDX_W-1:0]  segment_index,
	input  logic [ADDR_W-1:0]     segment_start,
	input  logic [ADDR_W-1:0]     segment_shift,
	input  logic                  segment_bad,
	input  logic [ADDR_W-1:0]     lookup_addr,
	output logic                  done,
	output logic [ADDR_W-1:0]     result_addr,
	output logic                  status
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_CMP  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [AW_REG_W-1:0]    addr_width_q;
	logic [CNT_REG_W-1:0]   seg_count_q;
	logic                   fwd_en_q;
	logic [MAX_SEGMENTS-1:0] valid_q;

	logic                   done_q;
	logic [ADDR_W-1:0]      result_q;
	logic                   status_q;

	logic                   is_fwd_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [ADDR_W-1:0]      top_q;
	logic [ADDR_W-1:0]      sign_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       k_q;

	logic [ADDR_W-1:0]      cur_start_q;
	logic [ADDR_W-1:0]      cur_off_q;
	logic                   cur_bad_q;
	logic [ADDR_W-1:0]      cur_lo_q;
	logic [ADDR_W-1:0]      hi_q;
	logic [ADDR_W-1:0]      prev_start_q;
	logic [ADDR_W-1:0]      prev_off_q;
	logic                   prev_bad_q;
	logic [ADDR_W-1:0]      prev_lo_q;

	logic                   accept;
	logic [AW_REG_W-1:0]    eff_width;
	logic [CNT_W-1:0]       eff_count;
	logic                   wr_ok;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	seg_entry_t             ram_wdata;
	logic                   ram_re;
	seg_entry_t             ram_rdata;
	logic                   in_use;
	logic                   entry_ok;
	logic [ADDR_W-1:0]      ld_start;
	logic [ADDR_W-1:0]      ld_off;
	logic                   ld_bad;
	logic                   last_seg;
	logic                   fwd_hit;
	logic                   rev_hit;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Effective width and segment count after clamping.
	assign eff_width = (addr_width_q < AW_REG_W'(2)) ? AW_REG_W'(2) : addr_width_q;
	assign eff_count = (32'(seg_count_q) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
		: CNT_W'(seg_count_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_width_q <= AW_RESET;
			seg_count_q  <= CNT_RESET;
			fwd_en_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ADDR_WIDTH: addr_width_q <= cfg_wdata[AW_REG_W-1:0];
				CFG_SEG_COUNT:  seg_count_q  <= cfg_wdata[CNT_REG_W-1:0];
				CFG_FWD_ENABLE: fwd_en_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Segment write port of the table.
	assign wr_ok     = 32'(segment_index) < MAX_SEGMENTS;
	assign ram_we    = accept && (func_t'(func) == FN_WRITE) && wr_ok;
	assign ram_waddr = IDX_W'(segment_index);
	assign ram_wdata = '{start: segment_start, shift: segment_shift, bad: segment_bad};
	assign ram_re    = (state_q == ST_READ) && (k_q < cnt_q);

	sat_ram #(
		.WIDTH($bits(seg_entry_t)),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(IDX_W'(k_q)),
		.rdata(ram_rdata)
	);

	// Entry valid bits; an entry never written reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// Decode of the entry that the RAM returns, with sentinels past the count.
	assign in_use   = k_q < cnt_q;
	assign entry_ok = in_use && valid_q[IDX_W'(k_q)];
	always_comb begin
		if (!in_use) begin
			ld_start = top_q;
		end else if (k_q == '0) begin
			ld_start = '0;
		end else if (entry_ok) begin
			ld_start = ram_rdata.start;
		end else begin
			ld_start = '0;
		end
		ld_off = entry_ok ? ((ram_rdata.shift ^ sign_q) - sign_q) : '0;
		ld_bad = entry_ok && ram_rdata.bad;
	end

	// Range checks of the segment before the current entry.
	assign last_seg = (k_q == cnt_q);
	assign fwd_hit  = (k_q != '0) && (prev_start_q <= addr_q) && (cur_start_q > addr_q);
	assign rev_hit  = (k_q != '0) && (prev_lo_q <= addr_q) && (hi_q > addr_q) && !prev_bad_q;

	// Sequencer and walk control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						unique case (func_t'(func))
							FN_WRITE: done_q <= 1'b1;
							FN_FORWARD: begin
								if (!fwd_en_q || (eff_count == '0)) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_READ;
								end
							end
							FN_REVERSE: begin
								if (eff_count == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_READ;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CMP;
				ST_CMP: begin
					if ((is_fwd_q ? fwd_hit : rev_hit) || last_seg) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_READ;
						k_q     <= k_q + CNT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Lookup context captured at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			is_fwd_q <= (func_t'(func) == FN_FORWARD);
			addr_q   <= lookup_addr;
			top_q    <= ADDR_W'(1) << eff_width;
			sign_q   <= ADDR_W'(1) << (eff_width - AW_REG_W'(1));
			cnt_q    <= eff_count;
		end
	end

	// Entry datapath: load, shifted bounds, then hand over to the previous slot.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			cur_start_q <= ld_start;
			cur_off_q   <= ld_off;
			cur_bad_q   <= ld_bad;
		end
		if (state_q == ST_SUM) begin
			hi_q     <= cur_start_q + prev_off_q;
			cur_lo_q <= cur_start_q + cur_off_q;
		end
		if (state_q == ST_CMP) begin
			prev_start_q <= cur_start_q;
			prev_off_q   <= cur_off_q;
			prev_bad_q   <= cur_bad_q;
			prev_lo_q    <= cur_lo_q;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= '0;
			status_q <= 1'b1;
			unique case (func_t'(func))
				FN_WRITE: status_q <= 1'b0;
				FN_FORWARD: begin
					if (!fwd_en_q) begin
						result_q <= lookup_addr;
						status_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_CMP) begin
			result_q <= '0;
			status_q <= 1'b1;
			if (is_fwd_q && fwd_hit && !prev_bad_q) begin
				result_q <= addr_q + prev_off_q;
				status_q <= 1'b0;
			end else if (!is_fwd_q && rev_hit) begin
				result_q <= addr_q - prev_off_q;
				status_q <= 1'b0;
			end
		end
	end

	assign done        = done_q;
	assign result_addr = result_q;
	assign status      = status_q;

endmodule

[rtl/sat_ram.sv]
// ----------------------------------------------------------------------------
// sat_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data is registered and
// appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module sat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/sat_checker.sv]
// ----------------------------------------------------------------------------
// sat_checker: port-level checks of the segmented address translator
// Watches the start/busy/done word handshake and the result word.
// ----------------------------------------------------------------------------
module sat_checker
	import sat_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [ADDR_W-1:0] result_addr,
	input logic              status
);

	// A result word only appears once the block is free again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done shown while busy");

	// An accepted word either starts a walk or answers in the next cycle.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word neither busy nor answered");

	// The end of a walk always delivers its result word.
	a_walk_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result word");

	// A failed lookup returns a zero address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (result_addr == '0))
		else $error("invalid status with nonzero address");

endmodule

bind segmented_address_translator_core sat_checker u_sat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.result_addr(result_addr),
	.status     (status)
);
